// File: rtl/uam_pkg.sv
// Shared constants, codes and types of the undirected adjacency matrix block.
`timescale 1ns / 1ps
`default_nettype none
package uam_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int ID_W  = 32;
  localparam int ACT_W = 3;
  localparam int STS_W = 3;

  // Request codes.
  localparam logic [ACT_W-1:0] ACT_ADD_V = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DEL_V = 3'd1;
  localparam logic [ACT_W-1:0] ACT_ADD_E = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DEL_E = 3'd3;
  localparam logic [ACT_W-1:0] ACT_QUERY = 3'd4;

  // Status codes.
  localparam logic [STS_W-1:0] STS_DONE    = 3'd0;
  localparam logic [STS_W-1:0] STS_EXISTS  = 3'd1;
  localparam logic [STS_W-1:0] STS_NONE    = 3'd2;
  localparam logic [STS_W-1:0] STS_MISSING = 3'd3;
  localparam logic [STS_W-1:0] STS_ADJ     = 3'd4;
  localparam logic [STS_W-1:0] STS_NOT_ADJ = 3'd5;
  localparam logic [STS_W-1:0] STS_FULL    = 3'd6;
  localparam logic [STS_W-1:0] STS_DUP     = 3'd7;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_DECIDE,
    S_EVAL_A,
    S_RD_B,
    S_WR_B,
    S_COL,
    S_COL_END,
    S_RESP
  } state_t;

  typedef struct packed {
    logic found_a;
    logic found_b;
    logic has_free;
  } scan_flags_t;

endpackage
`default_nettype wire

// File: rtl/undirected_adjacency_matrix.sv
// Top level of the undirected adjacency matrix: request sequencer and output register.
`timescale 1ns / 1ps
`default_nettype none
// Holds up to MAX_VERTICES vertex ids in slots and a symmetric bit matrix of edges over
// the slots. Each request on the input stream (add or remove a vertex, add or remove an
// edge, query adjacency) yields exactly one status transfer on the output stream. After
// reset the block clears the slot table and holds in_tready low meanwhile. Every request
// with a known code first scans the slot table one slot per cycle through a single compare
// unit, a rate set by the single read port of the slot memory; vertex removal then frees
// the found slot, an edge request does a read-modify-write of one or two matrix rows
// (a query only reads one), and a vertex add runs a second pass that clears the new slot's
// column row by row. Unknown request codes are answered with a done status and no scan.
// The result register lets the next request be taken while the previous status still waits.
module undirected_adjacency_matrix #(
  parameter int MAX_VERTICES = uam_pkg::MAX_VERTICES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // action[2:0], first_id[34:3], second_id[66:35]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata   // status[2:0]
);

  localparam int N  = MAX_VERTICES;
  localparam int SW = $clog2(N);
  localparam int IW = uam_pkg::ID_W;

  uam_pkg::state_t state_r, state_nxt;
  logic [SW-1:0]   cnt_r, cnt_nxt;
  logic            pend_r, pend_nxt;
  logic [SW-1:0]   idx_d_r, idx_d_nxt;
  logic [SW-1:0]   tgt_r, tgt_nxt;
  logic [uam_pkg::STS_W-1:0] sts_r, sts_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [uam_pkg::STS_W-1:0] out_sts_r, out_sts_nxt;
  logic [uam_pkg::ACT_W-1:0] act_r, act_nxt;
  logic [IW-1:0]   ida_r, ida_nxt;
  logic [IW-1:0]   idb_r, idb_nxt;

  logic            accept;
  logic            out_load;
  logic            last;

  logic            sm_we;
  logic [SW-1:0]   sm_waddr;
  logic            sm_wvalid;
  logic            sm_rvalid;
  logic [IW-1:0]   sm_rid;

  logic            rm_we;
  logic [SW-1:0]   rm_waddr;
  logic [N-1:0]    rm_wdata;
  logic [SW-1:0]   rm_raddr;
  logic [N-1:0]    rm_rdata;

  logic            scan_clr;
  logic            scan_en;
  uam_pkg::scan_flags_t flags;
  logic [SW-1:0]   slot_a;
  logic [SW-1:0]   slot_b;
  logic [SW-1:0]   free_slot;

  logic [N-1:0]    mask_a;
  logic [N-1:0]    mask_b;
  logic [N-1:0]    mask_t;

  uam_slot_mem #(.N(N)) u_slot_mem (
    .clk    (clk),
    .we     (sm_we),
    .waddr  (sm_waddr),
    .wvalid (sm_wvalid),
    .wid    (ida_r),
    .raddr  (cnt_r),
    .rvalid (sm_rvalid),
    .rid    (sm_rid)
  );

  uam_row_mem #(.N(N)) u_row_mem (
    .clk   (clk),
    .we    (rm_we),
    .waddr (rm_waddr),
    .wdata (rm_wdata),
    .raddr (rm_raddr),
    .rdata (rm_rdata)
  );

  uam_scan #(.N(N)) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (scan_clr),
    .en        (scan_en),
    .ent_valid (sm_rvalid),
    .ent_id    (sm_rid),
    .ent_idx   (idx_d_r),
    .key_a     (ida_r),
    .key_b     (idb_r),
    .flags     (flags),
    .slot_a    (slot_a),
    .slot_b    (slot_b),
    .free_slot (free_slot)
  );

  assign accept = in_tvalid && in_tready;
  assign last   = (cnt_r == SW'(N - 1));
  assign mask_a = N'(1) << slot_a;
  assign mask_b = N'(1) << slot_b;
  assign mask_t = N'(1) << tgt_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = 1'b0;
    idx_d_nxt = cnt_r;
    tgt_nxt   = tgt_r;
    sts_nxt   = sts_r;
    in_tready = 1'b0;
    out_load  = 1'b0;
    sm_we     = 1'b0;
    sm_waddr  = cnt_r;
    sm_wvalid = 1'b0;
    rm_we     = 1'b0;
    rm_waddr  = idx_d_r;
    rm_wdata  = rm_rdata;
    rm_raddr  = cnt_r;
    scan_clr  = 1'b0;
    scan_en   = 1'b0;
    act_nxt   = act_r;
    ida_nxt   = ida_r;
    idb_nxt   = idb_r;

    unique case (state_r)
      uam_pkg::S_CLEAR: begin
        sm_we   = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (last) begin
          cnt_nxt   = '0;
          state_nxt = uam_pkg::S_IDLE;
        end
      end
      uam_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          act_nxt = in_tdata[2:0];
          ida_nxt = in_tdata[34:3];
          idb_nxt = in_tdata[66:35];
          if (in_tdata[2:0] > uam_pkg::ACT_QUERY) begin
            sts_nxt   = uam_pkg::STS_DONE;
            state_nxt = uam_pkg::S_RESP;
          end else begin
            scan_clr  = 1'b1;
            cnt_nxt   = '0;
            state_nxt = uam_pkg::S_SCAN;
          end
        end
      end
      uam_pkg::S_SCAN: begin
        // Read data of the previous slot arrives while the next address is issued.
        scan_en  = pend_r;
        pend_nxt = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (last) begin
          cnt_nxt   = '0;
          state_nxt = uam_pkg::S_SCAN_END;
        end
      end
      uam_pkg::S_SCAN_END: begin
        scan_en   = pend_r;
        state_nxt = uam_pkg::S_DECIDE;
      end
      uam_pkg::S_DECIDE: begin
        priority case (act_r)
          uam_pkg::ACT_ADD_V: begin
            if (flags.found_a) begin
              sts_nxt   = uam_pkg::STS_DUP;
              state_nxt = uam_pkg::S_RESP;
            end else if (!flags.has_free) begin
              sts_nxt   = uam_pkg::STS_FULL;
              state_nxt = uam_pkg::S_RESP;
            end else begin
              sm_we     = 1'b1;
              sm_waddr  = free_slot;
              sm_wvalid = 1'b1;
              tgt_nxt   = free_slot;
              cnt_nxt   = '0;
              state_nxt = uam_pkg::S_COL;
            end
          end
          uam_pkg::ACT_DEL_V: begin
            // Stale matrix bits of a freed slot are cleared when the slot is reused.
            if (!flags.found_a) begin
              sts_nxt = uam_pkg::STS_MISSING;
            end else begin
              sm_we    = 1'b1;
              sm_waddr = slot_a;
              sts_nxt  = uam_pkg::STS_DONE;
            end
            state_nxt = uam_pkg::S_RESP;
          end
          default: begin
            if (!flags.found_a || !flags.found_b) begin
              sts_nxt   = uam_pkg::STS_MISSING;
              state_nxt = uam_pkg::S_RESP;
            end else begin
              rm_raddr  = slot_a;
              state_nxt = uam_pkg::S_EVAL_A;
            end
          end
        endcase
      end
      uam_pkg::S_EVAL_A: begin
        rm_waddr = slot_a;
        sts_nxt  = uam_pkg::STS_DONE;
        priority case (act_r)
          uam_pkg::ACT_ADD_E: begin
            if (rm_rdata[slot_b]) begin
              sts_nxt   = uam_pkg::STS_EXISTS;
              state_nxt = uam_pkg::S_RESP;
            end else begin
              rm_we     = 1'b1;
              rm_wdata  = rm_rdata | mask_b;
              state_nxt = uam_pkg::S_RD_B;
            end
          end
          uam_pkg::ACT_DEL_E: begin
            if (!rm_rdata[slot_b]) begin
              sts_nxt   = uam_pkg::STS_NONE;
              state_nxt = uam_pkg::S_RESP;
            end else begin
              rm_we     = 1'b1;
              rm_wdata  = rm_rdata & ~mask_b;
              state_nxt = uam_pkg::S_RD_B;
            end
          end
          default: begin
            sts_nxt   = rm_rdata[slot_b] ? uam_pkg::STS_ADJ : uam_pkg::STS_NOT_ADJ;
            state_nxt = uam_pkg::S_RESP;
          end
        endcase
      end
      uam_pkg::S_RD_B: begin
        // The mirror row is read only after the first write, so a self loop sees it.
        rm_raddr  = slot_b;
        state_nxt = uam_pkg::S_WR_B;
      end
      uam_pkg::S_WR_B: begin
        rm_we     = 1'b1;
        rm_waddr  = slot_b;
        rm_wdata  = (act_r == uam_pkg::ACT_ADD_E) ? (rm_rdata | mask_a)
                                                  : (rm_rdata & ~mask_a);
        state_nxt = uam_pkg::S_RESP;
      end
      uam_pkg::S_COL: begin
        // Clear the new slot's column in every row, and its own row entirely.
        pend_nxt = 1'b1;
        rm_we    = pend_r;
        rm_wdata = (idx_d_r == tgt_r) ? '0 : (rm_rdata & ~mask_t);
        cnt_nxt  = cnt_r + 1'b1;
        if (last) begin
          cnt_nxt   = '0;
          state_nxt = uam_pkg::S_COL_END;
        end
      end
      uam_pkg::S_COL_END: begin
        rm_we     = pend_r;
        rm_wdata  = (idx_d_r == tgt_r) ? '0 : (rm_rdata & ~mask_t);
        sts_nxt   = uam_pkg::STS_DONE;
        state_nxt = uam_pkg::S_RESP;
      end
      uam_pkg::S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = uam_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = uam_pkg::S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_sts_nxt   = sts_r;
    end else begin
      out_valid_nxt = out_valid_r && !out_tready;
      out_sts_nxt   = out_sts_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= uam_pkg::S_CLEAR;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_d_r   <= idx_d_nxt;
    tgt_r     <= tgt_nxt;
    sts_r     <= sts_nxt;
    out_sts_r <= out_sts_nxt;
    act_r     <= act_nxt;
    ida_r     <= ida_nxt;
    idb_r     <= idb_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_sts_r};

`ifndef SYNTH
  // One request at a time: the input closes right after a transfer.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("input accepted a second request back to back");

  // A result is only presented by the response step of the sequencer.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == uam_pkg::S_RESP))
    else $error("result appeared outside the response step");

  // Matrix rows are written only while an edge add or removal or a vertex add is carried out.
  a_row_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    rm_we |-> (state_r == uam_pkg::S_EVAL_A || state_r == uam_pkg::S_WR_B ||
               state_r == uam_pkg::S_COL || state_r == uam_pkg::S_COL_END))
    else $error("matrix row written outside an update step");

  // A held result is never overwritten before its transfer.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !out_load)
    else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

// File: rtl/uam_slot_mem.sv
// Slot table memory: one valid bit and one vertex id per slot, registered read.
`timescale 1ns / 1ps
`default_nettype none
module uam_slot_mem #(
  parameter int N = uam_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [$clog2(N)-1:0]      waddr,
  input  wire logic                      wvalid,
  input  wire logic [uam_pkg::ID_W-1:0]  wid,
  input  wire logic [$clog2(N)-1:0]      raddr,
  output logic                           rvalid,
  output logic      [uam_pkg::ID_W-1:0]  rid
);

  logic [uam_pkg::ID_W:0] mem [N];
  logic [uam_pkg::ID_W:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wvalid, wid};
    end
    rdata_r <= mem[raddr];
  end

  assign rvalid = rdata_r[uam_pkg::ID_W];
  assign rid    = rdata_r[uam_pkg::ID_W-1:0];

endmodule
`default_nettype wire

// File: rtl/uam_row_mem.sv
// Adjacency row memory: one bit row per slot, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module uam_row_mem #(
  parameter int N = uam_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(N)-1:0] waddr,
  input  wire logic [N-1:0]         wdata,
  input  wire logic [$clog2(N)-1:0] raddr,
  output logic      [N-1:0]         rdata
);

  logic [N-1:0] mem [N];
  logic [N-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: rtl/uam_scan.sv
// Shared compare unit: matches a slot entry per enabled cycle to both ids, tracks a free slot.
`timescale 1ns / 1ps
`default_nettype none
module uam_scan #(
  parameter int N = uam_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      clr,
  input  wire logic                      en,
  input  wire logic                      ent_valid,
  input  wire logic [uam_pkg::ID_W-1:0]  ent_id,
  input  wire logic [$clog2(N)-1:0]      ent_idx,
  input  wire logic [uam_pkg::ID_W-1:0]  key_a,
  input  wire logic [uam_pkg::ID_W-1:0]  key_b,
  output uam_pkg::scan_flags_t           flags,
  output logic      [$clog2(N)-1:0]      slot_a,
  output logic      [$clog2(N)-1:0]      slot_b,
  output logic      [$clog2(N)-1:0]      free_slot
);

  localparam int SW = $clog2(N);

  uam_pkg::scan_flags_t flags_r, flags_nxt;
  logic [SW-1:0] slot_a_r, slot_a_nxt;
  logic [SW-1:0] slot_b_r, slot_b_nxt;
  logic [SW-1:0] free_r, free_nxt;

  always_comb begin
    flags_nxt  = flags_r;
    slot_a_nxt = slot_a_r;
    slot_b_nxt = slot_b_r;
    free_nxt   = free_r;
    if (clr) begin
      flags_nxt = '0;
    end else if (en) begin
      if (ent_valid) begin
        if (ent_id == key_a && !flags_r.found_a) begin
          flags_nxt.found_a = 1'b1;
          slot_a_nxt        = ent_idx;
        end
        if (ent_id == key_b && !flags_r.found_b) begin
          flags_nxt.found_b = 1'b1;
          slot_b_nxt        = ent_idx;
        end
      end else if (!flags_r.has_free) begin
        // Slots are scanned upward, so the first free one seen is the lowest.
        flags_nxt.has_free = 1'b1;
        free_nxt           = ent_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_a_r <= slot_a_nxt;
    slot_b_r <= slot_b_nxt;
    free_r   <= free_nxt;
  end

  assign flags     = flags_r;
  assign slot_a    = slot_a_r;
  assign slot_b    = slot_b_r;
  assign free_slot = free_r;

endmodule
`default_nettype wire
